@@ rtl/sgrg_pkg.sv @@
// ----------------------------------------------------------------------------
// sgrg_pkg
// Shared types, constants and font helpers for the scaled glyph row generator.
// ----------------------------------------------------------------------------
`default_nettype none

package sgrg_pkg;

    localparam int CODE_BITS      = 8;
    localparam int COORD_BITS     = 12;
    localparam int SCALE_BITS     = 4;
    localparam int ROW_BITS       = 44;
    localparam int PANEL_X_BITS   = 13;
    localparam int WIDTH_BITS     = 6;
    localparam int GLYPH_COLS     = 5;
    localparam int GLYPH_ROWS     = 7;
    localparam int GROW_BITS      = 3;
    localparam int DEF_MAX_SCALE  = 9;
    localparam int PANEL_X_OFFSET = 6;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [COORD_BITS-1:0] SCREEN_RESET = COORD_BITS'(466);

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SCREEN_WIDTH  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SCREEN_HEIGHT = CFG_INDEX_BITS'(1);

    typedef struct packed {
        logic [CODE_BITS-1:0]  char_code;
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
        logic [SCALE_BITS-1:0] scale;
    } in_item_t;

    typedef struct packed {
        logic [ROW_BITS-1:0]     row_bits;
        logic [PANEL_X_BITS-1:0] panel_x;
        logic [COORD_BITS-1:0]   panel_y;
        logic [WIDTH_BITS-1:0]   row_width;
        logic                    is_last;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic advance;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_bounds;
        logic last_row;
    } dp_status_t;

    typedef logic [GLYPH_ROWS-1:0][GLYPH_COLS-1:0] glyph_t;
    typedef logic [GLYPH_COLS-1:0][ROW_BITS-1:0]   col_mask_t;

    function automatic glyph_t pack_glyph(
        input logic [4:0] r0, input logic [4:0] r1, input logic [4:0] r2,
        input logic [4:0] r3, input logic [4:0] r4, input logic [4:0] r5,
        input logic [4:0] r6);
        return {r6, r5, r4, r3, r2, r1, r0};
    endfunction

    // font ROM, row 0 is the top row, bit 4 the leftmost column
    function automatic glyph_t glyph_rows(input logic [CODE_BITS-1:0] code);
        glyph_t g;
        case (code)
            8'h3A:   g = pack_glyph(5'd0,  5'd4,  5'd0,  5'd0,  5'd4,  5'd0,  5'd0);  // :
            8'h2C:   g = pack_glyph(5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd4,  5'd8);  // ,
            8'h30:   g = pack_glyph(5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14);
            8'h31:   g = pack_glyph(5'd4,  5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd14);
            8'h32:   g = pack_glyph(5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd8,  5'd31);
            8'h33:   g = pack_glyph(5'd30, 5'd1,  5'd1,  5'd14, 5'd1,  5'd1,  5'd30);
            8'h34:   g = pack_glyph(5'd2,  5'd6,  5'd10, 5'd18, 5'd31, 5'd2,  5'd2);
            8'h35:   g = pack_glyph(5'd31, 5'd16, 5'd16, 5'd30, 5'd1,  5'd1,  5'd30);
            8'h36:   g = pack_glyph(5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14);
            8'h37:   g = pack_glyph(5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd8,  5'd8);
            8'h38:   g = pack_glyph(5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14);
            8'h39:   g = pack_glyph(5'd14, 5'd17, 5'd17, 5'd15, 5'd1,  5'd1,  5'd14);
            8'h43:   g = pack_glyph(5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14); // C
            8'h44:   g = pack_glyph(5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30); // D
            8'h45:   g = pack_glyph(5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31); // E
            8'h48:   g = pack_glyph(5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17); // H
            8'h4C:   g = pack_glyph(5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31); // L
            8'h4F:   g = pack_glyph(5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14); // O
            8'h52:   g = pack_glyph(5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17); // R
            8'h54:   g = pack_glyph(5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4);  // T
            8'h55:   g = pack_glyph(5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14); // U
            8'h57:   g = pack_glyph(5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10); // W
            8'h58:   g = pack_glyph(5'd17, 5'd17, 5'd10, 5'd4,  5'd10, 5'd17, 5'd17); // X
            8'h59:   g = pack_glyph(5'd17, 5'd17, 5'd10, 5'd4,  5'd4,  5'd4,  5'd4);  // Y
            default: g = '0;  // space and unsupported codes
        endcase
        return g;
    endfunction

    // per glyph column, the pixels of a cell row it covers at this scale
    function automatic col_mask_t col_masks(input logic [SCALE_BITS-1:0] sc);
        col_mask_t m;
        int        s;
        int        cw;
        m  = '0;
        s  = int'(sc);
        cw = (GLYPH_COLS * s) & ~1;
        for (int k = 0; k < GLYPH_COLS; k++) begin
            for (int px = 0; px < ROW_BITS; px++) begin
                if (px >= k * s && px < (k + 1) * s && px < cw) begin
                    m[k][px] = 1'b1;
                end
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

@@ rtl/sgrg_ctrl.sv @@
// ----------------------------------------------------------------------------
// sgrg_ctrl
// Sequencer: take a character, check it, then walk out its cell rows.
// ----------------------------------------------------------------------------
`default_nettype none

module sgrg_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  wire logic               m_ready,
    input  wire sgrg_pkg::dp_status_t status,
    output sgrg_pkg::ctrl_cmd_t     cmd
);
    import sgrg_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                state_next = status.in_bounds ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (m_ready && status.last_row) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        m_valid     = 1'b0;
        unique case (state_reg)
            ST_IDLE:  s_ready = 1'b1;
            ST_CHECK: ;
            ST_EMIT:  m_valid = 1'b1;
            default:  ;
        endcase
        cmd.load    = s_valid && s_ready;
        cmd.advance = m_valid && m_ready;
    end

endmodule

`default_nettype wire

@@ rtl/sgrg_datapath.sv @@
// ----------------------------------------------------------------------------
// sgrg_datapath
// Screen registers, character latch, bounds check and row counters.
// ----------------------------------------------------------------------------
`default_nettype none

module sgrg_datapath #(
    parameter int MAX_SCALE = sgrg_pkg::DEF_MAX_SCALE
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_valid,
    input  wire logic [sgrg_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [sgrg_pkg::COORD_BITS-1:0]      cfg_data,
    input  wire sgrg_pkg::in_item_t                   s_data,
    input  wire sgrg_pkg::ctrl_cmd_t                  cmd,
    output sgrg_pkg::dp_status_t                      status,
    output sgrg_pkg::out_item_t                       m_data
);
    import sgrg_pkg::*;

    logic [COORD_BITS-1:0] sw_reg, sw_next;
    logic [COORD_BITS-1:0] sh_reg, sh_next;

    glyph_t                glyph_reg, glyph_next;
    col_mask_t             cmask_reg, cmask_next;
    logic [COORD_BITS-1:0] x_reg, x_next;
    logic [COORD_BITS-1:0] y_reg, y_next;
    logic [SCALE_BITS-1:0] sc_reg, sc_next;
    logic [WIDTH_BITS-1:0] cw_reg, cw_next;
    logic [WIDTH_BITS-1:0] chh_reg, chh_next;
    logic [WIDTH_BITS-1:0] py_reg, py_next;
    logic [SCALE_BITS-1:0] sy_reg, sy_next;
    logic [GROW_BITS-1:0]  gr_reg, gr_next;

    logic [SCALE_BITS+2:0]   cw_full;
    logic [SCALE_BITS+2:0]   chh_full;
    logic [COORD_BITS:0]     x_end;
    logic [COORD_BITS:0]     y_end;
    logic [GLYPH_COLS-1:0]   grow;
    logic [ROW_BITS-1:0]     row_bits;

    // config registers
    always_comb begin
        sw_next = sw_reg;
        sh_next = sh_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SCREEN_WIDTH:  sw_next = cfg_data;
                CFG_SCREEN_HEIGHT: sh_next = cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sw_reg <= SCREEN_RESET;
            sh_reg <= SCREEN_RESET;
        end else begin
            sw_reg <= sw_next;
            sh_reg <= sh_next;
        end
    end

    // cell size, rounded down to even
    assign cw_full  = (SCALE_BITS + 3)'(GLYPH_COLS) * {3'b000, s_data.scale};
    assign chh_full = (SCALE_BITS + 3)'(GLYPH_ROWS) * {3'b000, s_data.scale};

    always_comb begin
        glyph_next = glyph_reg;
        cmask_next = cmask_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        sc_next    = sc_reg;
        cw_next    = cw_reg;
        chh_next   = chh_reg;
        py_next    = py_reg;
        sy_next    = sy_reg;
        gr_next    = gr_reg;
        if (cmd.load) begin
            glyph_next = glyph_rows(s_data.char_code);
            cmask_next = col_masks(s_data.scale);
            x_next     = {s_data.pos_x[COORD_BITS-1:1], 1'b0};
            y_next     = {s_data.pos_y[COORD_BITS-1:1], 1'b0};
            sc_next    = s_data.scale;
            cw_next    = {cw_full[WIDTH_BITS-1:1], 1'b0};
            chh_next   = {chh_full[WIDTH_BITS-1:1], 1'b0};
            py_next    = '0;
            sy_next    = '0;
            gr_next    = '0;
        end else if (cmd.advance) begin
            py_next = py_reg + WIDTH_BITS'(1);
            if (sy_reg == sc_reg - SCALE_BITS'(1)) begin
                sy_next = '0;
                gr_next = gr_reg + GROW_BITS'(1);
            end else begin
                sy_next = sy_reg + SCALE_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        glyph_reg <= glyph_next;
        cmask_reg <= cmask_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        sc_reg    <= sc_next;
        cw_reg    <= cw_next;
        chh_reg   <= chh_next;
        py_reg    <= py_next;
        sy_reg    <= sy_next;
        gr_reg    <= gr_next;
    end

    // bounds check, evaluated the cycle after the latch
    assign x_end = {1'b0, x_reg} + (COORD_BITS + 1)'(cw_reg);
    assign y_end = {1'b0, y_reg} + (COORD_BITS + 1)'(chh_reg);

    assign status.in_bounds = (sc_reg != '0)
                           && (sc_reg <= SCALE_BITS'(MAX_SCALE))
                           && (x_reg < sw_reg) && (y_reg < sh_reg)
                           && (x_end <= {1'b0, sw_reg})
                           && (y_end <= {1'b0, sh_reg});
    assign status.last_row  = (py_reg + WIDTH_BITS'(1)) == chh_reg;

    // row expansion: each glyph column lights its run of pixels
    assign grow = glyph_reg[gr_reg];

    always_comb begin
        row_bits = '0;
        for (int k = 0; k < GLYPH_COLS; k++) begin
            if (grow[GLYPH_COLS-1-k]) row_bits = row_bits | cmask_reg[k];
        end
    end

    assign m_data.row_bits  = row_bits;
    assign m_data.panel_x   = {1'b0, x_reg} + PANEL_X_BITS'(PANEL_X_OFFSET);
    assign m_data.panel_y   = y_reg + COORD_BITS'(py_reg);
    assign m_data.row_width = cw_reg;
    assign m_data.is_last   = status.last_row;

endmodule

`default_nettype wire

@@ rtl/scaled_glyph_row_generator_top.sv @@
// ----------------------------------------------------------------------------
// scaled_glyph_row_generator_top
// 5x7 font character renderer: one scaled character in, one mask per row out.
// ----------------------------------------------------------------------------
// Each input beat carries a character code, a cell position and a scale.
// The character is looked up in a 24-symbol 5x7 font (unknown codes draw as
// blank), scaled, and emitted as one output beat per cell row, top to bottom:
// a foreground mask (bit 0 leftmost), the panel column (x plus 6), the panel
// row, the cell width and a last-row flag. Cell width is 5*scale and height
// 7*scale, each rounded down to even; x and y are rounded down to even.
// A cell that does not lie fully inside screen_width x screen_height, or has
// a scale of zero or above MAX_SCALE, produces no output at all.
// A character is accepted, checked in a bounds-check state, then emitted
// as one row per cycle while m_ready is high; a rejected character goes
// back to idle after the check. The block holds one character at a time.
// Config writes (index 0 width, 1 height) are always accepted and should
// only be issued while the block is idle.
`default_nettype none

module scaled_glyph_row_generator_top #(
    parameter int MAX_SCALE = sgrg_pkg::DEF_MAX_SCALE
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // config write channel
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [sgrg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [sgrg_pkg::COORD_BITS-1:0]     cfg_data,
    // character input
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire sgrg_pkg::in_item_t                  s_data,
    // row output
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output sgrg_pkg::out_item_t                      m_data
);
    import sgrg_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // config registers never back-pressure
    assign cfg_ready = 1'b1;

    // controller: idle -> check -> emit rows
    sgrg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // datapath: holds the character, screen size and row counters;
    // the output beat is built straight from its registers
    sgrg_datapath #(
        .MAX_SCALE (MAX_SCALE)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .cmd       (cmd),
        .status    (status),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

@@ rtl/sgrg_checker.sv @@
// ----------------------------------------------------------------------------
// sgrg_checker
// Port-level checks on the row output sequence, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sgrg_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_ready,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire sgrg_pkg::out_item_t m_data
);
    import sgrg_pkg::*;

    // one character at a time: no new beat taken while rows are pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken while rows pending");

    // stalled output beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("output beat changed under stall");

    // rows of a cell follow one another without gaps
    a_rows_contiguous: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_data.is_last) |=> m_valid)
        else $error("gap inside a character cell");

    // next row sits one panel line lower, same column and width
    a_row_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_data.is_last) |=>
            (m_data.panel_y == COORD_BITS'($past(m_data.panel_y) + 1'b1))
            && $stable(m_data.panel_x) && $stable(m_data.row_width))
        else $error("row step mismatch");

    // last row closes the cell
    a_last_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_data.is_last) |=> !m_valid)
        else $error("output continued past last row");

endmodule

bind scaled_glyph_row_generator_top sgrg_checker u_sgrg_checker (.*);

`default_nettype wire
